@@ hdl/dpalu_pkg.sv @@
// ----------------------------------------------------------------------------
// dpalu_pkg
// Types, codes and helper functions for the data-processing ALU with
// barrel shifter.
// ----------------------------------------------------------------------------
package dpalu_pkg;

  // Data-processing opcodes in instruction encoding order.
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } opcode_t;

  // Shift types from bits 6:5 of the operand field.
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_t;

  localparam int unsigned WordWidth = 32;

  // One instruction as captured at the input transfer.
  typedef struct packed {
    logic [3:0]  opcode;
    logic        set_flags;
    logic        immediate_form;
    logic [11:0] operand_field;
    logic [31:0] first_operand;
    logic [31:0] shift_source;
    logic [7:0]  shift_register_byte;
    logic        rn_is_pc;
    logic        rd_is_pc;
    logic        carry_in;
    logic        overflow_in;
    logic        thumb_mode;
  } instr_t;

  // One finished result.
  typedef struct packed {
    logic [31:0] result;
    logic        write_result;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        flags_written;
    logic        restore_status;
    logic        pc_written;
  } result_t;

  // Shifter output: value and carry out.
  typedef struct packed {
    logic [31:0] value;
    logic        carry;
  } shift_out_t;

  // Shift by an amount of 1 to 31. The extra bit below or above the word
  // catches the last bit shifted out, which becomes the carry.
  function automatic shift_out_t shift_small(shift_type_t kind, logic [4:0] amt,
                                             logic [31:0] v);
    shift_out_t        o;
    logic [32:0]       left;
    logic [32:0]       right;
    logic signed [32:0] arith;
    logic [63:0]       rot;
    left  = {1'b0, v} << amt;
    right = {v, 1'b0} >> amt;
    arith = $signed({v, 1'b0}) >>> amt;
    rot   = {v, v} >> amt;
    unique case (kind)
      SH_LSL: begin
        o.value = left[31:0];
        o.carry = left[32];
      end
      SH_LSR: begin
        o.value = right[32:1];
        o.carry = right[0];
      end
      SH_ASR: begin
        o.value = arith[32:1];
        o.carry = arith[0];
      end
      default: begin
        o.value = rot[31:0];
        o.carry = rot[31];
      end
    endcase
    return o;
  endfunction

endpackage

@@ hdl/data_processing_alu_with_shifter.sv @@
// ----------------------------------------------------------------------------
// data_processing_alu_with_shifter
// Execute stage for one data-processing instruction: operand-2 barrel
// shifter, 32-bit ALU and flag logic, between an input and a result register.
// ----------------------------------------------------------------------------
// An instruction passes the input register, then the result register.
// Throughput: one instruction per cycle while out_ready is high; the shifter
// and the single 32-bit adder sit between the input and result registers.
// Both stages advance when the stage ahead is empty or being drained.
// Reset clears both stage valid bits; payload registers are not reset.
module data_processing_alu_with_shifter
  import dpalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic        set_flags,
  input  logic        immediate_form,
  input  logic [11:0] operand_field,
  input  logic [31:0] first_operand,
  input  logic [31:0] shift_source,
  input  logic [7:0]  shift_register_byte,
  input  logic        rn_is_pc,
  input  logic        rd_is_pc,
  input  logic        carry_in,
  input  logic        overflow_in,
  input  logic        thumb_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result,
  output logic        write_result,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_c,
  output logic        flag_v,
  output logic        flags_written,
  output logic        restore_status,
  output logic        pc_written
);

  instr_t     ir;
  logic       ir_valid;
  result_t    rr;
  logic       rr_valid;
  logic       rr_load;
  result_t    rr_next;

  shift_type_t kind;
  logic [4:0]  amt5;
  shift_out_t  shifted;
  shift_out_t  imm_sh;
  logic [31:0] imm_rot;
  logic [4:0]  rot_amt;
  logic [31:0] op1;
  logic [31:0] op2;
  logic        sh_carry;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic        alu_cy;
  logic        arith;
  logic [32:0] sum;
  logic [31:0] res;
  logic        c_out;
  logic        v_out;
  logic        wr;
  logic        fw;
  opcode_t     op;

  // Handshake: the result stage loads when empty or being drained.
  assign rr_load  = !rr_valid || out_ready;
  assign in_ready = !ir_valid || rr_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ready) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ir <= '{opcode, set_flags, immediate_form, operand_field, first_operand,
              shift_source, shift_register_byte, rn_is_pc, rd_is_pc, carry_in,
              overflow_in, thumb_mode};
    end
  end

  // Second operand: rotated immediate or shifted register.
  always_comb begin
    kind    = shift_type_t'(ir.operand_field[6:5]);
    amt5    = ir.operand_field[4] ? ir.shift_register_byte[4:0] : ir.operand_field[11:7];
    shifted = shift_small(kind, amt5, ir.shift_source);
    rot_amt = {ir.operand_field[11:8], 1'b0};
    imm_sh  = shift_small(SH_ROR, rot_amt, {24'd0, ir.operand_field[7:0]});
    imm_rot = imm_sh.value;
    op2      = ir.shift_source;
    sh_carry = ir.carry_in;
    if (ir.immediate_form) begin
      if (ir.thumb_mode) begin
        op2 = {20'd0, ir.operand_field};
      end else if (rot_amt == 5'd0) begin
        op2 = {24'd0, ir.operand_field[7:0]};
      end else begin
        op2      = imm_rot;
        sh_carry = imm_rot[31];
      end
    end else if (ir.operand_field[4]) begin
      // Shift amount from a register; zero leaves value and carry alone.
      if (ir.shift_register_byte == 8'd0) begin
        op2 = ir.shift_source;
      end else if (ir.shift_register_byte[7:5] == 3'd0) begin
        op2      = shifted.value;
        sh_carry = shifted.carry;
      end else begin
        unique case (kind)
          SH_LSL: begin
            op2      = '0;
            sh_carry = (ir.shift_register_byte == 8'd32) && ir.shift_source[0];
          end
          SH_LSR: begin
            op2      = '0;
            sh_carry = (ir.shift_register_byte == 8'd32) && ir.shift_source[31];
          end
          SH_ASR: begin
            op2      = {WordWidth{ir.shift_source[31]}};
            sh_carry = ir.shift_source[31];
          end
          default: begin
            // A rotate by a multiple of 32 keeps the value, carry is bit 31.
            if (amt5 == 5'd0) begin
              sh_carry = ir.shift_source[31];
            end else begin
              op2      = shifted.value;
              sh_carry = shifted.carry;
            end
          end
        endcase
      end
    end else if (amt5 != 5'd0) begin
      op2      = shifted.value;
      sh_carry = shifted.carry;
    end else begin
      // Immediate amount of zero: LSR and ASR mean 32, ROR means RRX.
      unique case (kind)
        SH_LSL: begin
          op2 = ir.shift_source;
        end
        SH_LSR: begin
          op2      = '0;
          sh_carry = ir.shift_source[31];
        end
        SH_ASR: begin
          op2      = {WordWidth{ir.shift_source[31]}};
          sh_carry = ir.shift_source[31];
        end
        default: begin
          op2      = {ir.carry_in, ir.shift_source[31:1]};
          sh_carry = ir.shift_source[0];
        end
      endcase
    end
  end

  // ALU and flags.
  always_comb begin
    op1 = ir.first_operand;
    if (ir.rn_is_pc && !ir.rd_is_pc) begin
      op1[1] = 1'b0;
    end
    op     = opcode_t'(ir.opcode);
    alu_a  = op1;
    alu_b  = op2;
    alu_cy = 1'b0;
    arith  = 1'b0;
    res    = '0;
    unique case (op)
      OP_AND, OP_TST: res = op1 & op2;
      OP_EOR, OP_TEQ: res = op1 ^ op2;
      OP_SUB, OP_CMP: begin
        arith = 1'b1;
        alu_b = ~op2;
        alu_cy = 1'b1;
      end
      OP_RSB: begin
        arith = 1'b1;
        alu_a = op2;
        alu_b = ~op1;
        alu_cy = 1'b1;
      end
      OP_ADD, OP_CMN: arith = 1'b1;
      OP_ADC: begin
        arith = 1'b1;
        alu_cy = ir.carry_in;
      end
      OP_SBC: begin
        arith = 1'b1;
        alu_b = ~op2;
        alu_cy = ir.carry_in;
      end
      OP_RSC: begin
        arith = 1'b1;
        alu_a = op2;
        alu_b = ~op1;
        alu_cy = ir.carry_in;
      end
      OP_ORR: res = op1 | op2;
      OP_MOV: res = op2;
      OP_BIC: res = op1 & ~op2;
      OP_MVN: res = ~op2;
    endcase
    sum   = {1'b0, alu_a} + {1'b0, alu_b} + {32'd0, alu_cy};
    c_out = sh_carry;
    v_out = ir.overflow_in;
    if (arith) begin
      res   = sum[31:0];
      c_out = sum[32];
      v_out = (alu_a[31] == alu_b[31]) && (alu_a[31] != sum[31]);
    end
    wr = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
    fw = ir.set_flags && !ir.rd_is_pc;
    rr_next.result         = wr ? res : '0;
    rr_next.write_result   = wr;
    rr_next.flag_n         = fw && res[31];
    rr_next.flag_z         = fw && (res == '0);
    rr_next.flag_c         = fw ? c_out : ir.carry_in;
    rr_next.flag_v         = fw ? v_out : ir.overflow_in;
    rr_next.flags_written  = fw;
    rr_next.restore_status = ir.set_flags && ir.rd_is_pc;
    rr_next.pc_written     = wr && ir.rd_is_pc;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rr_valid <= 1'b0;
    end else if (rr_load) begin
      rr_valid <= ir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rr_load && ir_valid) begin
      rr <= rr_next;
    end
  end

  assign out_valid      = rr_valid;
  assign result         = rr.result;
  assign write_result   = rr.write_result;
  assign flag_n         = rr.flag_n;
  assign flag_z         = rr.flag_z;
  assign flag_c         = rr.flag_c;
  assign flag_v         = rr.flag_v;
  assign flags_written  = rr.flags_written;
  assign restore_status = rr.restore_status;
  assign pc_written     = rr.pc_written;

  // Flag write and status restore exclude each other.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(flags_written && restore_status))
    else $error("flags_written and restore_status both set");

  // A PC write is always a register write.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && pc_written) |-> write_result)
    else $error("pc_written without write_result");

  // Compare and test opcodes deliver a zero result.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_result) |-> (result == '0))
    else $error("non-zero result on a compare or test");

  // A transfer into an empty input stage is held there the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !ir_valid) |=> ir_valid)
    else $error("accepted instruction lost from input stage");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the data-processing ALU with barrel shifter. Instructions are
// pushed through the valid/ready input with and without random gaps. Each
// accepted instruction is executed by an independent predictor and each result
// transfer is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top
  import dpalu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transfer on either side before the run is declared hung.
  localparam int unsigned StallLimit = 2000;
  // Length of the deliberate receiver hold-off.
  localparam int unsigned HoldCycles = 100;

  // Keeps predicted results in order and compares them with what comes out.
  class alu_scoreboard;
    result_t     pending[$];
    int unsigned instr_count;
    int unsigned writeback_count;
    int unsigned error_count;
    int unsigned big_shifts;
    int unsigned pc_writes;
    logic [15:0] opcodes_seen;

    // Shift by 1 to 31 places; returns {carry, value}.
    function logic [32:0] shift_word(shift_type_t kind, int unsigned n, logic [31:0] v);
      logic [31:0] val;
      logic        cout;
      cout = v[n - 1];
      case (kind)
        SH_LSL: begin
          val  = v << n;
          cout = v[32 - n];
        end
        SH_LSR:  val = v >> n;
        SH_ASR:  val = $signed(v) >>> n;
        default: val = (v >> n) | (v << (32 - n));
      endcase
      return {cout, val};
    endfunction

    // Executes one instruction: operand-2 shifter, ALU and flag rules.
    function result_t execute_instr(instr_t x);
      logic [31:0] op1;
      logic [31:0] op2;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] res;
      logic [32:0] sum;
      logic        c;
      logic        v;
      logic        cy;
      logic        arith;
      logic        wr;
      logic        fw;
      int unsigned amt;
      shift_type_t kind;
      result_t     r;
      c     = x.carry_in;
      v     = x.overflow_in;
      op1   = x.first_operand;
      op2   = x.shift_source;
      res   = '0;
      arith = 1'b0;
      kind  = shift_type_t'(x.operand_field[6:5]);

      // Second operand.
      if (x.immediate_form) begin
        if (x.thumb_mode) begin
          op2 = {20'd0, x.operand_field};
        end else begin
          amt = 2 * x.operand_field[11:8];
          op2 = {24'd0, x.operand_field[7:0]};
          if (amt != 0) {c, op2} = shift_word(SH_ROR, amt, op2);
        end
      end else if (x.operand_field[4]) begin
        // Amount from the low byte of Rs; 32 and above follow their own rules.
        amt = x.shift_register_byte;
        if (amt >= 32) begin
          case (kind)
            SH_LSL: begin
              c   = (amt == 32) ? op2[0] : 1'b0;
              op2 = '0;
            end
            SH_LSR: begin
              c   = (amt == 32) ? op2[31] : 1'b0;
              op2 = '0;
            end
            SH_ASR: begin
              c   = op2[31];
              op2 = {32{op2[31]}};
            end
            default: begin
              if (amt % 32 == 0) c = op2[31];
              else {c, op2} = shift_word(SH_ROR, amt % 32, op2);
            end
          endcase
        end else if (amt != 0) begin
          {c, op2} = shift_word(kind, amt, op2);
        end
      end else begin
        // Immediate amount; zero encodes a shift by 32 or RRX except for LSL.
        amt = x.operand_field[11:7];
        if (amt != 0) begin
          {c, op2} = shift_word(kind, amt, op2);
        end else begin
          case (kind)
            SH_LSL: ;
            SH_LSR: begin
              c   = op2[31];
              op2 = '0;
            end
            SH_ASR: begin
              c   = op2[31];
              op2 = {32{op2[31]}};
            end
            default: begin
              c   = op2[0];
              op2 = {x.carry_in, op2[31:1]};
            end
          endcase
        end
      end

      // A PC read as Rn has bit 1 cleared unless the PC is also the target.
      if (x.rn_is_pc && !x.rd_is_pc) op1[1] = 1'b0;

      a  = op1;
      b  = op2;
      cy = 1'b0;
      case (opcode_t'(x.opcode))
        OP_AND, OP_TST: res = op1 & op2;
        OP_EOR, OP_TEQ: res = op1 ^ op2;
        OP_SUB, OP_CMP: begin
          arith = 1'b1;
          b     = ~op2;
          cy    = 1'b1;
        end
        OP_RSB: begin
          arith = 1'b1;
          a     = op2;
          b     = ~op1;
          cy    = 1'b1;
        end
        OP_ADD, OP_CMN: arith = 1'b1;
        OP_ADC: begin
          arith = 1'b1;
          cy    = x.carry_in;
        end
        OP_SBC: begin
          arith = 1'b1;
          b     = ~op2;
          cy    = x.carry_in;
        end
        OP_RSC: begin
          arith = 1'b1;
          a     = op2;
          b     = ~op1;
          cy    = x.carry_in;
        end
        OP_ORR:  res = op1 | op2;
        OP_MOV:  res = op2;
        OP_BIC:  res = op1 & ~op2;
        default: res = ~op2;
      endcase
      if (arith) begin
        sum = {1'b0, a} + {1'b0, b} + {32'd0, cy};
        res = sum[31:0];
        c   = sum[32];
        v   = (a[31] == b[31]) && (a[31] != res[31]);
      end

      // Write enables and flag outputs.
      wr = !(opcode_t'(x.opcode) inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      fw = x.set_flags && !x.rd_is_pc;
      r.result         = wr ? res : '0;
      r.write_result   = wr;
      r.flag_n         = fw & res[31];
      r.flag_z         = fw & (res == '0);
      r.flag_c         = fw ? c : x.carry_in;
      r.flag_v         = fw ? v : x.overflow_in;
      r.flags_written  = fw;
      r.restore_status = x.set_flags && x.rd_is_pc;
      r.pc_written     = wr && x.rd_is_pc;
      return r;
    endfunction

    // Called for every input transfer.
    function void note_instr(instr_t x);
      result_t r;
      r = execute_instr(x);
      pending.push_back(r);
      instr_count++;
      opcodes_seen[x.opcode] = 1'b1;
      if (!x.immediate_form && x.operand_field[4] && x.shift_register_byte >= 32)
        big_shifts++;
      if (r.pc_written) pc_writes++;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %h, got %h", name, want, got);
        error_count++;
      end
    endfunction

    // Called for every result transfer.
    function void check_writeback(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result transfer with nothing outstanding: result %h", got.result);
        error_count++;
        return;
      end
      want = pending.pop_front();
      writeback_count++;
      check_field("result", want.result, got.result);
      check_field("write_result", want.write_result, got.write_result);
      check_field("flag_n", want.flag_n, got.flag_n);
      check_field("flag_z", want.flag_z, got.flag_z);
      check_field("flag_c", want.flag_c, got.flag_c);
      check_field("flag_v", want.flag_v, got.flag_v);
      check_field("flags_written", want.flags_written, got.flags_written);
      check_field("restore_status", want.restore_status, got.restore_status);
      check_field("pc_written", want.pc_written, got.pc_written);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  opcode = '0;
  logic        set_flags = 1'b0;
  logic        immediate_form = 1'b0;
  logic [11:0] operand_field = '0;
  logic [31:0] first_operand = '0;
  logic [31:0] shift_source = '0;
  logic [7:0]  shift_register_byte = '0;
  logic        rn_is_pc = 1'b0;
  logic        rd_is_pc = 1'b0;
  logic        carry_in = 1'b0;
  logic        overflow_in = 1'b0;
  logic        thumb_mode = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result;
  logic        write_result;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;
  logic        flags_written;
  logic        restore_status;
  logic        pc_written;

  result_t       out_word;
  alu_scoreboard sb;
  bit            no_idle = 1'b0;
  bit            hold_request = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;

  assign out_word = {result, write_result, flag_n, flag_z, flag_c, flag_v,
                     flags_written, restore_status, pc_written};

  data_processing_alu_with_shifter uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each transfer, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_writeback(out_word);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
        out_ready <= 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one instruction and returns at the edge where it transfers.
  task automatic send_instr(instr_t x);
    opcode              <= x.opcode;
    set_flags           <= x.set_flags;
    immediate_form      <= x.immediate_form;
    operand_field       <= x.operand_field;
    first_operand       <= x.first_operand;
    shift_source        <= x.shift_source;
    shift_register_byte <= x.shift_register_byte;
    rn_is_pc            <= x.rn_is_pc;
    rd_is_pc            <= x.rd_is_pc;
    carry_in            <= x.carry_in;
    overflow_in         <= x.overflow_in;
    thumb_mode          <= x.thumb_mode;
    in_valid            <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_instr(x);
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic wait_for_writebacks();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  // Register values weighted toward the corners of the flag logic.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t x;
    x.opcode         = 4'($urandom_range(15));
    x.set_flags      = 1'($urandom_range(1));
    x.immediate_form = ($urandom_range(2) == 0);
    x.operand_field  = 12'($urandom_range(4095));
    x.first_operand  = pick_word();
    x.shift_source   = pick_word();
    case ($urandom_range(5))
      0:       x.shift_register_byte = 8'd0;
      1:       x.shift_register_byte = 8'd32;
      2:       x.shift_register_byte = 8'($urandom_range(31, 1));
      3:       x.shift_register_byte = 8'($urandom_range(255, 33));
      4:       x.shift_register_byte = {3'($urandom_range(7)), 5'd0};
      default: x.shift_register_byte = 8'($urandom());
    endcase
    x.rn_is_pc    = ($urandom_range(3) == 0);
    x.rd_is_pc    = ($urandom_range(3) == 0);
    x.carry_in    = 1'($urandom_range(1));
    x.overflow_in = 1'($urandom_range(1));
    x.thumb_mode  = ($urandom_range(3) == 0);
    // Favor the zero-amount encodings and equal operands for compares.
    if (x.immediate_form && $urandom_range(3) == 0) x.operand_field[11:8] = '0;
    if (!x.immediate_form && !x.operand_field[4] && $urandom_range(3) == 0)
      x.operand_field[11:7] = '0;
    if ($urandom_range(7) == 0) x.first_operand = x.shift_source;
    return x;
  endfunction

  task automatic send_random(int unsigned count, bit gaps);
    repeat (count) begin
      if (gaps) begin
        while ($urandom_range(99) < 33) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      send_instr(random_instr());
    end
  endtask

  // Corner cases of the shifter, every opcode and the PC and flag rules.
  // Columns: opcode, S, I, field, Rn, Rm, Rs byte, Rn=PC, Rd=PC, C, V, T.
  task automatic run_directed();
    instr_t d[$];
    // Thumb immediate, zero rotate, rotate by two and by thirty.
    d.push_back(instr_t'{OP_AND, 1'b1, 1'b1, 12'hfff, 32'hffff_ffff, 32'h0, 8'd0,
                         1'b0, 1'b0, 1'b1, 1'b0, 1'b1});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b1, 12'h0ff, 32'h0, 32'h0, 8'd0,
                         1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b1, 12'h1ff, 32'h0, 32'h0, 8'd0,
                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MVN, 1'b1, 1'b1, 12'hf81, 32'h0, 32'h0, 8'd0,
                         1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
    // Immediate shift of zero for each type: LSL keeps, LSR/ASR by 32, RRX; then LSL by 31.
    d.push_back(instr_t'{OP_ORR, 1'b1, 1'b0, {5'd0, SH_LSL, 1'b0, 4'd0}, 32'h0,
                         32'h8000_0001, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_EOR, 1'b1, 1'b0, {5'd0, SH_LSR, 1'b0, 4'd0}, 32'h0,
                         32'h8000_0000, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_BIC, 1'b1, 1'b0, {5'd0, SH_ASR, 1'b0, 4'd0}, 32'hffff_ffff,
                         32'h8000_0000, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {5'd0, SH_ROR, 1'b0, 4'd0}, 32'h0,
                         32'h0000_0001, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {5'd31, SH_LSL, 1'b0, 4'd0}, 32'h0,
                         32'h0000_0003, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    // Register shifts: zero, exactly 32, beyond 32, multiples of 32 and 33 on ROR.
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {4'd0, 1'b0, SH_LSL, 1'b1, 4'd0}, 32'h0,
                         32'h1234_5678, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {4'd0, 1'b0, SH_LSL, 1'b1, 4'd0}, 32'h0,
                         32'h0000_0001, 8'd32, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_TST, 1'b1, 1'b0, {4'd0, 1'b0, SH_LSR, 1'b1, 4'd0},
                         32'hffff_ffff, 32'hffff_ffff, 8'd33, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_TEQ, 1'b1, 1'b0, {4'd0, 1'b0, SH_LSR, 1'b1, 4'd0}, 32'h0,
                         32'h8000_0000, 8'd32, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_CMP, 1'b1, 1'b0, {4'd0, 1'b0, SH_ASR, 1'b1, 4'd0},
                         32'hffff_ffff, 32'h8000_0000, 8'd200, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_CMN, 1'b1, 1'b0, {4'd0, 1'b0, SH_ASR, 1'b1, 4'd0}, 32'h0,
                         32'h7fff_ffff, 8'd40, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {4'd0, 1'b0, SH_ROR, 1'b1, 4'd0}, 32'h0,
                         32'h8000_0001, 8'd64, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {4'd0, 1'b0, SH_ROR, 1'b1, 4'd0}, 32'h0,
                         32'h0000_0003, 8'd33, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    // Bit 7 of a register-shift field is ignored.
    d.push_back(instr_t'{OP_MOV, 1'b1, 1'b0, {4'd0, 1'b1, SH_ROR, 1'b1, 4'd0}, 32'h0,
                         32'h0000_0180, 8'd8, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    // Arithmetic with carry and overflow corners, and the PC rules.
    d.push_back(instr_t'{OP_SUB, 1'b1, 1'b0, 12'd0, 32'h8000_0002, 32'h0000_0001, 8'd0,
                         1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_RSB, 1'b1, 1'b0, 12'd0, 32'h0000_0002, 32'h0, 8'd0,
                         1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_ADD, 1'b1, 1'b0, 12'd0, 32'hffff_ffff, 32'h0000_0001, 8'd0,
                         1'b0, 1'b0, 1'b0, 1'b1, 1'b0});
    d.push_back(instr_t'{OP_ADC, 1'b1, 1'b0, 12'd0, 32'h7fff_ffff, 32'h0, 8'd0,
                         1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    d.push_back(instr_t'{OP_SBC, 1'b0, 1'b0, 12'd0, 32'h0, 32'h0, 8'd0,
                         1'b0, 1'b1, 1'b1, 1'b1, 1'b0});
    d.push_back(instr_t'{OP_RSC, 1'b1, 1'b0, 12'd0, 32'h0000_0005, 32'h8000_0000, 8'd0,
                         1'b0, 1'b1, 1'b1, 1'b0, 1'b0});
    foreach (d[i]) send_instr(d[i]);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    wait_for_writebacks();

    // Random traffic with idling on both sides.
    send_random(600, 1'b1);
    wait_for_writebacks();

    // Receiver holds off while the sender keeps offering: the pipe fills up.
    hold_request = 1'b1;
    send_random(60, 1'b0);
    send_random(400, 1'b1);

    // Back-to-back stretch with no idling anywhere.
    no_idle = 1'b1;
    send_random(300, 1'b0);
    no_idle = 1'b0;
    send_random(250, 1'b1);

    wait_for_writebacks();
    repeat (6) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d predicted results never came out", sb.pending.size());
      sb.error_count++;
    end

    $display("Ran %0d instructions and checked %0d results over %0d of 16 opcodes,",
             sb.instr_count, sb.writeback_count, $countones(sb.opcodes_seen));
    $display("including %0d register shifts of 32 or more and %0d writes to the PC.",
             sb.big_shifts, sb.pc_writes);
    if (sb.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
